@@ src/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant check failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/fps_pkg.sv @@
// types, codes and constants of the flight phase sequencer
// used by every module of the block; no dependencies
package fps_pkg;

  typedef enum logic [2:0] {
    PH_UNARMED   = 3'd0,
    PH_PRELAUNCH = 3'd1,
    PH_ASCENT    = 3'd2,
    PH_DESCENT   = 3'd3,
    PH_ACTIVE    = 3'd4,
    PH_LANDED    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_FORCE     = 2'd1,
    KIND_PID_START = 2'd2,
    KIND_PID_STOP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_LAUNCH_ALT     = 3'd0,
    CFG_LAUNCH_SPD     = 3'd1,
    CFG_LAUNCH_ALT_LOW = 3'd2,
    CFG_LAUNCH_SPD_LOW = 3'd3,
    CFG_APOGEE_DROP    = 3'd4,
    CFG_DEPLOY_ALT     = 3'd5,
    CFG_LANDED_ALT     = 3'd6,
    CFG_LANDED_SPD     = 3'd7
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  localparam logic [31:0] PID_DELAY_MS = 32'd500;

  typedef struct packed {
    logic [15:0] launch_alt;
    logic [14:0] launch_spd;
    logic [15:0] launch_alt_low;
    logic [14:0] launch_spd_low;
    logic [15:0] apogee_drop;
    logic [15:0] deploy_alt;
    logic [15:0] landed_alt;
    logic [14:0] landed_spd;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    launch_alt:     16'd500,
    launch_spd:     15'd200,
    launch_alt_low: 16'd200,
    launch_spd_low: 15'd100,
    apogee_drop:    16'd200,
    deploy_alt:     16'd4600,
    landed_alt:     16'd200,
    landed_spd:     15'd40
  };

  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_ms;
    logic [23:0] altitude;
    logic [15:0] climb_rate;
    logic [2:0]  target_phase;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] entry_time;
    logic [23:0] peak_alt;
    logic        pid_en;
    logic [31:0] pid_start;
    logic        pid_first;
    logic        slow_rate;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_UNARMED,
    entry_time: 32'd0,
    peak_alt:   24'd0,
    pid_en:     1'b0,
    pid_start:  32'd0,
    pid_first:  1'b0,
    slow_rate:  1'b0
  };

  typedef struct packed {
    logic   bad_phase;
    logic   phase_entered;
    logic   slow_telemetry;
    logic   release_pulse;
    logic   buzzer_on;
    logic   camera_on;
    logic   clear_integral;
    logic   pid_drive;
    phase_t phase;
  } result_t;

  // minimum time in a phase before a threshold may move it on
  function automatic logic [16:0] min_dwell(input phase_t p);
    logic [16:0] d;
    case (p)
      PH_UNARMED:   d = 17'd1000;
      PH_PRELAUNCH: d = 17'd1000;
      PH_ASCENT:    d = 17'd2000;
      PH_DESCENT:   d = 17'd2000;
      PH_ACTIVE:    d = 17'd90000;
      PH_LANDED:    d = 17'd1000;
      default:      d = 17'd1000;
    endcase
    return d;
  endfunction

endpackage

@@ src/fps_cfg.sv @@
// configuration register file of the flight phase sequencer
// depends on fps_pkg
module fps_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fps_pkg::CFG_DATA_W-1:0]    cfg_data,
  output fps_pkg::cfg_t                     cfg_o
);

  fps_pkg::cfg_t cfg_r;
  fps_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (fps_pkg::cfg_idx_t'(cfg_index))
        fps_pkg::CFG_LAUNCH_ALT:     cfg_nxt.launch_alt     = cfg_data;
        fps_pkg::CFG_LAUNCH_SPD:     cfg_nxt.launch_spd     = cfg_data[14:0];
        fps_pkg::CFG_LAUNCH_ALT_LOW: cfg_nxt.launch_alt_low = cfg_data;
        fps_pkg::CFG_LAUNCH_SPD_LOW: cfg_nxt.launch_spd_low = cfg_data[14:0];
        fps_pkg::CFG_APOGEE_DROP:    cfg_nxt.apogee_drop    = cfg_data;
        fps_pkg::CFG_DEPLOY_ALT:     cfg_nxt.deploy_alt     = cfg_data;
        fps_pkg::CFG_LANDED_ALT:     cfg_nxt.landed_alt     = cfg_data;
        fps_pkg::CFG_LANDED_SPD:     cfg_nxt.landed_spd     = cfg_data[14:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= fps_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ src/fps_seq.sv @@
// phase state register and the single-pass next-state and result logic
// depends on fps_pkg
module fps_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  fps_pkg::item_t     item,
  input  fps_pkg::cfg_t      cfg,
  output fps_pkg::result_t   res
);

  fps_pkg::state_t st_r;
  fps_pkg::state_t st_nxt;

  logic [31:0]        elapsed;
  logic [31:0]        pid_elapsed;
  logic               dwell_ok;
  logic signed [24:0] alt_x;
  logic signed [16:0] vel_x;
  logic signed [16:0] vel_abs;
  logic [23:0]        peak_upd;
  logic signed [25:0] drop_lim;
  logic signed [25:0] alt26;
  logic               go;
  logic               enter;
  fps_pkg::phase_t    enter_ph;

  assign elapsed     = item.now_ms - st_r.entry_time;
  assign pid_elapsed = item.now_ms - st_r.pid_start;
  assign dwell_ok    = elapsed > {15'd0, fps_pkg::min_dwell(st_r.phase)};
  assign alt_x       = $signed({item.altitude[23], item.altitude});
  assign vel_x       = $signed({item.climb_rate[15], item.climb_rate});
  assign vel_abs     = vel_x[16] ? -vel_x : vel_x;
  assign peak_upd    = ($signed(item.altitude) > $signed(st_r.peak_alt)) ?
                       item.altitude : st_r.peak_alt;
  assign alt26       = $signed({{2{item.altitude[23]}}, item.altitude});
  assign drop_lim    = $signed({{2{peak_upd[23]}}, peak_upd})
                       - $signed({10'd0, cfg.apogee_drop});

  always_comb begin
    st_nxt   = st_r;
    res      = '0;
    res.phase = st_r.phase;
    go       = 1'b0;
    enter    = 1'b0;
    enter_ph = st_r.phase;

    case (item.kind)
      fps_pkg::KIND_TICK: begin
        // pid gate is evaluated before the phase tests
        if (st_r.pid_en && (pid_elapsed > fps_pkg::PID_DELAY_MS)) begin
          res.pid_drive = 1'b1;
          if (st_r.pid_first) begin
            res.clear_integral = 1'b1;
            st_nxt.pid_first   = 1'b0;
          end
        end
        case (st_r.phase)
          fps_pkg::PH_PRELAUNCH: begin
            go = (alt_x > $signed({9'd0, cfg.launch_alt}))
              || (vel_x > $signed({2'd0, cfg.launch_spd}))
              || ((alt_x > $signed({9'd0, cfg.launch_alt_low}))
                  && (vel_x > $signed({2'd0, cfg.launch_spd_low})));
          end
          fps_pkg::PH_ASCENT: begin
            st_nxt.peak_alt = peak_upd;
            go = alt26 < drop_lim;
          end
          fps_pkg::PH_DESCENT: begin
            go = alt_x < $signed({9'd0, cfg.deploy_alt});
          end
          fps_pkg::PH_ACTIVE: begin
            go = (alt_x < $signed({9'd0, cfg.landed_alt}))
              || (vel_abs < $signed({2'd0, cfg.landed_spd}));
          end
          default: go = 1'b0;
        endcase
        if (go && dwell_ok) begin
          enter    = 1'b1;
          enter_ph = fps_pkg::phase_t'(3'(st_r.phase) + 3'd1);
        end
      end
      fps_pkg::KIND_FORCE: begin
        if (item.target_phase <= 3'(fps_pkg::PH_LANDED)) begin
          enter    = 1'b1;
          enter_ph = fps_pkg::phase_t'(item.target_phase);
        end else begin
          res.bad_phase = 1'b1;
        end
      end
      fps_pkg::KIND_PID_START: begin
        res.clear_integral = 1'b1;
        st_nxt.pid_en      = 1'b1;
        st_nxt.pid_start   = item.now_ms;
        st_nxt.pid_first   = 1'b1;
      end
      fps_pkg::KIND_PID_STOP: begin
        res.clear_integral = 1'b1;
        st_nxt.pid_en      = 1'b0;
      end
      default: go = 1'b0;
    endcase

    // entry effects, applied after the pid gate
    if (enter) begin
      st_nxt.pid_en    = 1'b0;
      st_nxt.slow_rate = 1'b0;
      if (enter_ph == fps_pkg::PH_UNARMED || enter_ph == fps_pkg::PH_PRELAUNCH) begin
        st_nxt.peak_alt = '0;
      end
      if (enter_ph == fps_pkg::PH_ACTIVE) begin
        st_nxt.pid_en     = 1'b1;
        st_nxt.pid_start  = item.now_ms;
        st_nxt.pid_first  = 1'b1;
        res.release_pulse = 1'b1;
      end
      if (enter_ph == fps_pkg::PH_LANDED) begin
        st_nxt.slow_rate = 1'b1;
      end
      st_nxt.phase      = enter_ph;
      st_nxt.entry_time = item.now_ms;
      res.phase_entered = 1'b1;
    end

    res.phase          = st_nxt.phase;
    res.camera_on      = (st_nxt.phase == fps_pkg::PH_ASCENT)
                      || (st_nxt.phase == fps_pkg::PH_DESCENT)
                      || (st_nxt.phase == fps_pkg::PH_ACTIVE);
    res.buzzer_on      = st_nxt.phase == fps_pkg::PH_LANDED;
    res.slow_telemetry = st_nxt.slow_rate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fps_pkg::STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ src/flight_phase_sequencer_top.sv @@
// Flight phase sequencer: takes one item per clock cycle when the result side
// keeps up. An accepted item is held in the input register, is processed
// in a single pass against the phase state and lands in the result register, so
// its result is offered after both registers. The update loop of the phase
// state register sets the rate of one item per cycle; while the result register
// is full and not taken, one more item is held in the input register before
// in_tready drops. Configuration writes are registered in fps_cfg before use.
// depends on fps_pkg, fps_cfg, fps_seq and assert_macros.svh
`include "assert_macros.svh"

module flight_phase_sequencer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [fps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fps_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // now_ms[31:0], altitude[55:32], climb_rate[71:56], target_phase[74:72], zero pad
  input  logic [fps_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind[1:0]
  input  logic [fps_pkg::IN_USER_W-1:0]     in_tuser,
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // phase[2:0], pid_drive[3], clear_integral[4], camera_on[5], buzzer_on[6],
  // release_pulse[7], slow_telemetry[8], phase_entered[9], bad_phase[10], zero pad
  output logic [fps_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic               in_valid_r;
  fps_pkg::item_t     in_item_r;
  logic               out_valid_r;
  fps_pkg::result_t   out_res_r;
  logic               advance;
  logic               in_load;
  fps_pkg::cfg_t      cfg;
  fps_pkg::result_t   res;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_load   = in_tvalid && in_tready;

  fps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  fps_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item_r.kind         <= fps_pkg::kind_t'(in_tuser);
      in_item_r.now_ms       <= in_tdata[31:0];
      in_item_r.altitude     <= in_tdata[55:32];
      in_item_r.climb_rate   <= in_tdata[71:56];
      in_item_r.target_phase <= in_tdata[74:72];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

  // a stalled input register only happens behind a full result register
  `ASSERT_IMP(a_stall_needs_full_out, clk, rst_n, in_valid_r && !advance, out_valid_r)
  // release pulse only comes with an entry into the active phase
  `ASSERT_IMP(a_release_on_entry, clk, rst_n, out_valid_r && out_res_r.release_pulse, out_res_r.phase_entered && out_res_r.phase == fps_pkg::PH_ACTIVE)
  // a rejected forced target never causes an entry
  `ASSERT_IMP(a_bad_no_entry, clk, rst_n, out_valid_r && out_res_r.bad_phase, !out_res_r.phase_entered)
  // a processed item always shows a result in the next cycle
  `ASSERT_NEXT(a_advance_gives_out, clk, rst_n, advance, out_valid_r)

endmodule

@@ dv/flight_phase_sequencer_top_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for flight_phase_sequencer_top: scripted flights,
// noise and pid commands are streamed in and every result is checked field by field
// against an in-bench phase predictor; depends on fps_pkg and the rtl only
module flight_phase_sequencer_top_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam logic [31:0] PID_HOLDOFF_MS = 32'd500;
  localparam logic [2:0] NO_SUCH_PHASE = 3'd7;

  typedef enum {SET_RANDOM, SET_MAX, SET_ZERO, SET_MIXED} setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [fps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [fps_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [fps_pkg::IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [fps_pkg::OUT_DATA_W-1:0] out_tdata;

  flight_phase_sequencer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  fps_pkg::item_t pending_items[$];
  fps_pkg::result_t expected_results[$];
  fps_pkg::item_t offered;
  fps_pkg::result_t want_r, seen_r;

  int send_idle = 0;
  int recv_idle = 0;
  int items_queued = 0;
  int items_sent = 0;
  int results_seen = 0;
  int flights_queued = 0;
  int mismatches = 0;
  int hold_at = 0;
  bit hold_armed = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit stalled = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  // predictor copy of the sequencer state and registers
  fps_pkg::cfg_t fl_cfg = '{launch_alt: 16'd500, launch_spd: 15'd200,
                            launch_alt_low: 16'd200, launch_spd_low: 15'd100,
                            apogee_drop: 16'd200, deploy_alt: 16'd4600,
                            landed_alt: 16'd200, landed_spd: 15'd40};
  fps_pkg::phase_t fl_phase = fps_pkg::PH_UNARMED;
  logic [31:0] fl_entry_ms = 32'd0;
  int fl_peak = 0;
  logic pid_armed = 1'b0;
  logic [31:0] pid_t0 = 32'd0;
  logic pid_fresh = 1'b0;
  logic slow_tlm = 1'b0;
  logic entered_now, release_now;

  function automatic void enter_phase(fps_pkg::phase_t p, logic [31:0] t);
    pid_armed = 1'b0;
    slow_tlm = (p == fps_pkg::PH_LANDED);
    if (p <= fps_pkg::PH_PRELAUNCH) fl_peak = 0;
    if (p == fps_pkg::PH_ACTIVE) begin
      pid_armed = 1'b1;
      pid_t0 = t;
      pid_fresh = 1'b1;
      release_now = 1'b1;
    end
    fl_phase = p;
    fl_entry_ms = t;
    entered_now = 1'b1;
  endfunction

  function automatic fps_pkg::result_t next_flight_result(input fps_pkg::item_t it);
    fps_pkg::result_t r;
    logic [31:0] dwell;
    logic [31:0] since_entry;
    int alt_v, vel_v, mag;
    logic go;
    r = '0;
    entered_now = 1'b0;
    release_now = 1'b0;
    alt_v = int'($signed(it.altitude));
    vel_v = int'($signed(it.climb_rate));
    case (it.kind)
      fps_pkg::KIND_TICK: begin
        since_entry = it.now_ms - fl_entry_ms;
        case (fl_phase)
          fps_pkg::PH_ASCENT, fps_pkg::PH_DESCENT: dwell = 32'd2000;
          fps_pkg::PH_ACTIVE: dwell = 32'd90000;
          default: dwell = 32'd1000;
        endcase
        // pid gate goes first, on ticks only
        if (pid_armed && (it.now_ms - pid_t0) > PID_HOLDOFF_MS) begin
          r.pid_drive = 1'b1;
          if (pid_fresh) begin
            r.clear_integral = 1'b1;
            pid_fresh = 1'b0;
          end
        end
        go = 1'b0;
        case (fl_phase)
          fps_pkg::PH_PRELAUNCH: begin
            go = alt_v > int'(fl_cfg.launch_alt) || vel_v > int'(fl_cfg.launch_spd) ||
                 (alt_v > int'(fl_cfg.launch_alt_low) && vel_v > int'(fl_cfg.launch_spd_low));
          end
          fps_pkg::PH_ASCENT: begin
            if (alt_v > fl_peak) fl_peak = alt_v;
            go = alt_v < fl_peak - int'(fl_cfg.apogee_drop);
          end
          fps_pkg::PH_DESCENT: begin
            go = alt_v < int'(fl_cfg.deploy_alt);
          end
          fps_pkg::PH_ACTIVE: begin
            mag = (vel_v < 0) ? -vel_v : vel_v;
            go = alt_v < int'(fl_cfg.landed_alt) || mag < int'(fl_cfg.landed_spd);
          end
          default: go = 1'b0;
        endcase
        if (go && since_entry > dwell)
          enter_phase(fps_pkg::phase_t'(fl_phase + 1), it.now_ms);
      end
      fps_pkg::KIND_FORCE: begin
        if (it.target_phase <= fps_pkg::PH_LANDED)
          enter_phase(fps_pkg::phase_t'(it.target_phase), it.now_ms);
        else r.bad_phase = 1'b1;
      end
      fps_pkg::KIND_PID_START: begin
        r.clear_integral = 1'b1;
        pid_armed = 1'b1;
        pid_t0 = it.now_ms;
        pid_fresh = 1'b1;
      end
      default: begin
        r.clear_integral = 1'b1;
        pid_armed = 1'b0;
      end
    endcase
    r.phase = fl_phase;
    r.camera_on = (fl_phase >= fps_pkg::PH_ASCENT && fl_phase <= fps_pkg::PH_ACTIVE);
    r.buzzer_on = (fl_phase == fps_pkg::PH_LANDED);
    r.release_pulse = release_now;
    r.slow_telemetry = slow_tlm;
    r.phase_entered = entered_now;
    return r;
  endfunction

  function automatic void check_field(string name, logic [4:0] want, logic [4:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  function automatic void queue_item(fps_pkg::kind_t k, logic [31:0] t, int alt, int vel,
                                     logic [2:0] target);
    fps_pkg::item_t it;
    it.kind = k;
    it.now_ms = t;
    it.altitude = alt[23:0];
    it.climb_rate = vel[15:0];
    it.target_phase = target;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  // sender: one item offered at a time, held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(next_flight_result(offered));
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          offered = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, offered.target_phase, offered.climb_rate, offered.altitude,
                       offered.now_ms};
          in_tuser <= offered.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result, stalls at random, and once for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing pending: %h", out_tdata);
          mismatches++;
        end else begin
          want_r = expected_results.pop_front();
          seen_r = fps_pkg::result_t'(out_tdata[10:0]);
          check_field("phase", 5'(want_r.phase), 5'(seen_r.phase));
          check_field("pid_drive", 5'(want_r.pid_drive), 5'(seen_r.pid_drive));
          check_field("clear_integral", 5'(want_r.clear_integral),
                      5'(seen_r.clear_integral));
          check_field("camera_on", 5'(want_r.camera_on), 5'(seen_r.camera_on));
          check_field("buzzer_on", 5'(want_r.buzzer_on), 5'(seen_r.buzzer_on));
          check_field("release_pulse", 5'(want_r.release_pulse), 5'(seen_r.release_pulse));
          check_field("slow_telemetry", 5'(want_r.slow_telemetry),
                      5'(seen_r.slow_telemetry));
          check_field("phase_entered", 5'(want_r.phase_entered), 5'(seen_r.phase_entered));
          check_field("bad_phase", 5'(want_r.bad_phase), 5'(seen_r.bad_phase));
          check_field("pad", 5'd0, out_tdata[15:11]);
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_armed && !hold_used && results_seen >= hold_at) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // no-progress watchdog while work is outstanding
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pending_items.size() == 0 && !in_tvalid && expected_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      stalled <= 1'b1;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (stalled);
    $display("no item moved for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(fps_pkg::cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      fps_pkg::CFG_LAUNCH_ALT:     fl_cfg.launch_alt = val;
      fps_pkg::CFG_LAUNCH_SPD:     fl_cfg.launch_spd = val[14:0];
      fps_pkg::CFG_LAUNCH_ALT_LOW: fl_cfg.launch_alt_low = val;
      fps_pkg::CFG_LAUNCH_SPD_LOW: fl_cfg.launch_spd_low = val[14:0];
      fps_pkg::CFG_APOGEE_DROP:    fl_cfg.apogee_drop = val;
      fps_pkg::CFG_DEPLOY_ALT:     fl_cfg.deploy_alt = val;
      fps_pkg::CFG_LANDED_ALT:     fl_cfg.landed_alt = val;
      default:                     fl_cfg.landed_spd = val[14:0];
    endcase
  endtask

  task automatic load_settings(setting_t s);
    fps_pkg::cfg_idx_t idx;
    logic [15:0] top, val;
    for (int i = 0; i < 8; i++) begin
      idx = fps_pkg::cfg_idx_t'(i);
      top = (idx == fps_pkg::CFG_LAUNCH_SPD || idx == fps_pkg::CFG_LAUNCH_SPD_LOW ||
             idx == fps_pkg::CFG_LANDED_SPD) ? 16'h7FFF : 16'hFFFF;
      case (s)
        SET_MAX:  val = top;
        SET_ZERO: val = 16'd0;
        SET_MIXED: begin
          case ($urandom_range(2))
            0: val = 16'd0;
            1: val = top;
            default: val = 16'($urandom_range(top));
          endcase
        end
        default: val = 16'($urandom_range(top));
      endcase
      write_reg(idx, val);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // tick along a flight, sprinkled with pid commands and stray items
  task automatic flight_tick(int lo_ms, int hi_ms, int alt, int vel);
    int roll;
    clock_ms = clock_ms + $urandom_range(hi_ms, lo_ms);
    queue_item(fps_pkg::KIND_TICK, clock_ms, alt, vel, 3'($urandom_range(7)));
    roll = $urandom_range(99);
    if (roll < 3) begin
      queue_item(fps_pkg::KIND_PID_START, clock_ms, $urandom(), $urandom(),
                 3'($urandom_range(7)));
    end else if (roll < 5) begin
      queue_item(fps_pkg::KIND_PID_STOP, clock_ms, $urandom(), $urandom(),
                 3'($urandom_range(7)));
    end else if (roll < 9) begin
      queue_item(fps_pkg::kind_t'($urandom_range(3)),
                 ($urandom_range(1) != 0) ? $urandom() : clock_ms,
                 $urandom(), $urandom(), 3'($urandom_range(7)));
    end
  endtask

  task automatic queue_flight();
    int quiet_alt, quiet_vel, apex, low_alt, ground, n;
    flights_queued++;
    // some flights start close to the millisecond wrap
    if ($urandom_range(3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(150000);
    else clock_ms = clock_ms + $urandom_range(400, 50);
    queue_item(fps_pkg::KIND_FORCE, clock_ms, 0, 0, fps_pkg::PH_PRELAUNCH);

    quiet_alt = (fl_cfg.launch_alt < fl_cfg.launch_alt_low) ? int'(fl_cfg.launch_alt) :
                int'(fl_cfg.launch_alt_low);
    quiet_vel = (fl_cfg.launch_spd < fl_cfg.launch_spd_low) ? int'(fl_cfg.launch_spd) :
                int'(fl_cfg.launch_spd_low);
    n = $urandom_range(6, 2);
    for (int i = 0; i < n; i++)
      flight_tick(200, 600, $urandom_range(quiet_alt), $urandom_range(quiet_vel));

    apex = ((fl_cfg.launch_alt > fl_cfg.launch_alt_low) ? int'(fl_cfg.launch_alt) :
            int'(fl_cfg.launch_alt_low)) + $urandom_range(20000, 100);
    n = $urandom_range(16, 6);
    for (int i = 1; i <= n; i++)
      flight_tick(150, 400, apex * i / n, $urandom_range(32767));
    // a broken flight now and then
    if ($urandom_range(4) == 0) return;

    low_alt = apex - int'(fl_cfg.apogee_drop);
    if (low_alt > int'(fl_cfg.deploy_alt)) low_alt = int'(fl_cfg.deploy_alt);
    low_alt = low_alt - int'($urandom_range(300, 1));
    ground = (low_alt < int'(fl_cfg.landed_alt)) ? low_alt : int'(fl_cfg.landed_alt);
    ground = ground - int'($urandom_range(50, 1));
    n = $urandom_range(16, 8);
    for (int i = 1; i <= n; i++)
      flight_tick(200, 500, apex - (apex - low_alt) * i / n, -int'($urandom_range(3000, 10)));

    // long enough on the ground to pass the active dwell
    n = $urandom_range(22, 14);
    for (int i = 0; i < n; i++)
      flight_tick(8000, 16000, ground - int'($urandom_range(20)), int'($urandom_range(6)) - 3);
    n = $urandom_range(4, 2);
    for (int i = 0; i < n; i++)
      flight_tick(500, 3000, ground, 0);
  endtask

  task automatic queue_random(int count);
    int first;
    first = items_queued;
    while (items_queued - first < count) queue_flight();
  endtask

  task automatic queue_directed();
    queue_item(fps_pkg::KIND_TICK, 32'd0, 8388607, -32768, 3'd0);
    queue_item(fps_pkg::KIND_FORCE, 32'd50, -8388608, 32767, NO_SUCH_PHASE);
    queue_item(fps_pkg::KIND_FORCE, 32'd100, 0, 0, fps_pkg::PH_PRELAUNCH);
    // dwell exactly met is not enough
    queue_item(fps_pkg::KIND_TICK, 32'd1100, 501, 0, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd1101, 501, 0, 3'd0);
    queue_item(fps_pkg::KIND_FORCE, 32'd2000, 0, 0, fps_pkg::PH_PRELAUNCH);
    queue_item(fps_pkg::KIND_TICK, 32'd3001, 200, 101, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd3002, 0, 201, 3'd0);
    queue_item(fps_pkg::KIND_FORCE, 32'd4000, 0, 0, fps_pkg::PH_PRELAUNCH);
    queue_item(fps_pkg::KIND_TICK, 32'd5001, 201, 101, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd6000, 1000, 50, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd7002, 799, -50, 3'd0);
    queue_item(fps_pkg::KIND_FORCE, 32'd8000, 0, 0, fps_pkg::PH_ASCENT);
    queue_item(fps_pkg::KIND_FORCE, 32'd8000, 0, 0, fps_pkg::PH_DESCENT);
    queue_item(fps_pkg::KIND_TICK, 32'd10001, 4599, -100, 3'd0);
    // pid holdoff boundary, then first drive clears the integral
    queue_item(fps_pkg::KIND_TICK, 32'd10501, 4500, -100, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd10502, 4000, 0, 3'd0);
    queue_item(fps_pkg::KIND_PID_STOP, 32'd10600, 0, 0, 3'd0);
    queue_item(fps_pkg::KIND_PID_START, 32'd10700, 0, 0, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd11201, 4000, 100, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd100001, 5000, -39, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd100002, 5000, -39, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'd200000, -8388608, 32767, 3'd0);
    queue_item(fps_pkg::KIND_FORCE, 32'd200100, 0, 0, fps_pkg::PH_LANDED);
    // elapsed time across the millisecond wrap
    queue_item(fps_pkg::KIND_FORCE, 32'hFFFF_FF00, 0, 0, fps_pkg::PH_PRELAUNCH);
    queue_item(fps_pkg::KIND_PID_START, 32'hFFFF_FF00, 0, 0, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'h0000_0100, 600, 0, 3'd0);
    queue_item(fps_pkg::KIND_TICK, 32'h0000_02F0, 600, 0, 3'd0);
    queue_item(fps_pkg::KIND_FORCE, 32'h0000_0300, 0, 0, fps_pkg::PH_UNARMED);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 31;
    recv_idle = 65;
    queue_directed();
    wait_idle();
    load_settings(SET_RANDOM);
    queue_random(400);
    wait_idle();

    send_idle = 65;
    recv_idle = 31;
    load_settings(SET_MAX);
    queue_random(400);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    load_settings(SET_ZERO);
    hold_at = results_seen + 100;
    hold_armed = 1'b1;
    queue_random(200);
    wait_idle();
    load_settings(SET_MIXED);
    queue_random(200);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("%0d items over %0d flights, reset/random/max/zero/mixed registers, three idle mixes",
             items_sent, flights_queued);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/fps_pkg.sv
src/fps_cfg.sv
src/fps_seq.sv
src/flight_phase_sequencer_top.sv
dv/flight_phase_sequencer_top_tb.sv
